// File: sv/dbwc_pkg.sv
package dbwc_pkg;

	// Width of the sender clock; the round-trip sample is reduced to it.
	localparam int TIME_BITS = 32;
	localparam logic [31:0] SAMPLE_MASK = (TIME_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << TIME_BITS) - 64'd1);

	// A datagram is 1424 bytes = 16 * 89: the power of two is a shift,
	// the odd part is divided out digit by digit.
	localparam int DGRAM_BYTES = 1424;
	localparam int DGRAM_TZ    = 4;
	localparam int DGRAM_ODD   = DGRAM_BYTES >> DGRAM_TZ;

	// term_a = (lt * bw) / (256 * 1424), term_b = (rtt * bw) / (2 * 65536 * 1424)
	localparam int TERM_A_SHIFT = 8 + DGRAM_TZ;
	localparam int TERM_B_SHIFT = 17 + DGRAM_TZ;

	localparam int DIGIT_BITS  = 4;
	localparam int MUL_DIGITS  = 32 / DIGIT_BITS;
	localparam int DIV_WIDTH   = 44;
	localparam int DIV_DIGITS  = DIV_WIDTH / DIGIT_BITS;
	localparam int REM_BITS    = 7;
	localparam int CNT_BITS    = $clog2(DIV_DIGITS);

	localparam logic [7:0] WINDOW_CAP_RST   = 8'd100;
	localparam logic [7:0] WINDOW_FLOOR_RST = 8'd2;
	localparam logic [7:0] BACKOFF_STEP_RST = 8'd5;
	localparam logic [9:0] LATENCY_TGT_RST  = 10'd40;
	localparam logic [7:0] WINDOW_RST       = 8'd2;

	typedef enum logic [2:0] {
		CFG_WINDOW_CAP   = 3'd0,
		CFG_WINDOW_FLOOR = 3'd1,
		CFG_BACKOFF_STEP = 3'd2,
		CFG_LATENCY_TGT  = 3'd3
	} cfg_index_t;

	typedef enum logic {
		DIV_BY_FIVE,
		DIV_BY_DGRAM
	} divisor_t;

	typedef struct packed {
		logic load;
		logic step;
	} mul_ctl_t;

	typedef struct packed {
		logic     load;
		logic     step;
		divisor_t divisor;
	} div_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG_LD,
		ST_AVG_RUN,
		ST_MA_LD,
		ST_MA_RUN,
		ST_DA_LD,
		ST_DA_RUN,
		ST_MB_LD,
		ST_MB_RUN,
		ST_DB_LD,
		ST_DB_RUN,
		ST_UPD
	} state_t;

endpackage

// File: sv/dbwc_mul.sv
// Radix-16 serial multiplier: one 4-bit digit of the multiplier per step
// cycle, least significant first.
module dbwc_mul (
	input  logic              clk,
	input  dbwc_pkg::mul_ctl_t ctl,
	input  logic [31:0]       mcand,
	input  logic [31:0]       mplier,
	output logic [63:0]       product
);
	import dbwc_pkg::*;

	logic [31:0] x_q;
	logic [31:0] m_q;
	logic [63:0] p_q;
	logic [35:0] sum;

	assign sum = 36'(p_q[63:32]) + 36'(x_q) * 36'(m_q[DIGIT_BITS-1:0]);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= mcand;
			m_q <= mplier;
			p_q <= '0;
		end else if (ctl.step) begin
			p_q <= {sum, p_q[31:DIGIT_BITS]};
			m_q <= m_q >> DIGIT_BITS;
		end
	end

	assign product = p_q;

endmodule

// File: sv/dbwc_div.sv
// Serial divider by a small constant: one 4-bit digit of the dividend per step
// cycle, most significant first, restoring steps on a 7-bit remainder.
module dbwc_div (
	input  logic                              clk,
	input  dbwc_pkg::div_ctl_t                ctl,
	input  logic [dbwc_pkg::DIV_WIDTH-1:0]    dividend,
	output logic [dbwc_pkg::DIV_WIDTH-1:0]    quotient
);
	import dbwc_pkg::*;

	logic [DIV_WIDTH-1:0]  d_q;
	logic [DIV_WIDTH-1:0]  q_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [REM_BITS-1:0]   dsor;
	logic [REM_BITS-1:0]   rem_nxt;
	logic [DIGIT_BITS-1:0] qdig;

	always_comb begin
		unique case (ctl.divisor)
			DIV_BY_FIVE:  dsor = REM_BITS'(5);
			DIV_BY_DGRAM: dsor = REM_BITS'(DGRAM_ODD);
			default:      dsor = REM_BITS'(5);
		endcase
	end

	always_comb begin
		logic [REM_BITS:0] t;
		rem_nxt = rem_q;
		qdig    = '0;
		for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
			t = {rem_nxt, d_q[DIV_WIDTH-DIGIT_BITS+i]};
			if (t >= {1'b0, dsor}) begin
				rem_nxt = REM_BITS'(t - {1'b0, dsor});
				qdig[i] = 1'b1;
			end else begin
				rem_nxt = REM_BITS'(t);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			d_q   <= dividend;
			q_q   <= '0;
			rem_q <= '0;
		end else if (ctl.step) begin
			d_q   <= d_q << DIGIT_BITS;
			q_q   <= {q_q[DIV_WIDTH-DIGIT_BITS-1:0], qdig};
			rem_q <= rem_nxt;
		end
	end

	assign quotient = q_q;

endmodule

// File: sv/delay_based_window_controller.sv
// Delay-based congestion window controller. Each accepted ack item (send_time,
// ack_time, bandwidth) yields one result item: the updated congestion window
// and the smoothed round-trip time (UQ24.8 ms, new = 0.8*old + 0.2*sample).
// The window grows by one toward window_cap when the packet capacity
// (latency target plus half the RTT, times bandwidth, in 1424-byte datagrams)
// exceeds it, and otherwise drops by backoff_step, never below window_floor.
// The block takes no new item before it is through with the last one; the work
// runs on one shared 4-bit-per-cycle divider (three passes of 11 digits: the
// averaging divide by 5 and the two capacity divides by 89) and one shared
// 4-bit-per-cycle multiplier (two passes of 8 digits), run one after the other.
// in_stall is low only while no item is at work. The result sits in an output
// register, so a new item is taken while an earlier result still waits; a
// finished item holds in its last step only if that register is still full.
// Configuration writes are always taken.
module delay_based_window_controller (
	input  logic        clk,
	input  logic        arst_n,
	// ack channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] send_time,
	input  logic [31:0] ack_time,
	input  logic [31:0] bandwidth,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  window,
	output logic [31:0] rtt_smoothed,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import dbwc_pkg::*;

	state_t state_q, state_nxt;

	// configuration registers
	logic [7:0] cap_q;
	logic [7:0] floor_q;
	logic [7:0] step_q;
	logic [9:0] lat_q;

	// per-ack state
	logic [7:0]  window_q;
	logic [31:0] rtt_q;

	// working registers
	logic [31:0]          sample_q;
	logic [31:0]          bw_q;
	logic [29:0]          term_a_q;
	logic [CNT_BITS-1:0]  cnt_q;

	// output register
	logic        out_valid_q;
	logic [7:0]  out_window_q;
	logic [31:0] out_rtt_q;

	// arithmetic units
	mul_ctl_t             mul_ctl;
	div_ctl_t             div_ctl;
	logic [31:0]          mul_mcand;
	logic [63:0]          product;
	logic [DIV_WIDTH-1:0] dividend;
	logic [DIV_WIDTH-1:0] quotient;

	logic        in_take;
	logic        out_free;
	logic        cnt_done;
	logic [31:0] avg_sat;
	logic [44:0] capacity;
	logic        grow;
	logic [7:0]  cap_eff;
	logic [7:0]  floor_eff;
	logic [8:0]  win_inc;
	logic [7:0]  window_nxt;

	assign cfg_ready = 1'b1;
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cnt_done  = (cnt_q == '0);

	dbwc_mul u_mul (
		.clk     (clk),
		.ctl     (mul_ctl),
		.mcand   (mul_mcand),
		.mplier  (bw_q),
		.product (product)
	);

	dbwc_div u_div (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (dividend),
		.quotient (quotient)
	);

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_take) state_nxt = ST_AVG_LD;
			ST_AVG_LD:  state_nxt = ST_AVG_RUN;
			ST_AVG_RUN: if (cnt_done) state_nxt = ST_MA_LD;
			ST_MA_LD:   state_nxt = ST_MA_RUN;
			ST_MA_RUN:  if (cnt_done) state_nxt = ST_DA_LD;
			ST_DA_LD:   state_nxt = ST_DA_RUN;
			ST_DA_RUN:  if (cnt_done) state_nxt = ST_MB_LD;
			ST_MB_LD:   state_nxt = ST_MB_RUN;
			ST_MB_RUN:  if (cnt_done) state_nxt = ST_DB_LD;
			ST_DB_LD:   state_nxt = ST_DB_RUN;
			ST_DB_RUN:  if (cnt_done) state_nxt = ST_UPD;
			ST_UPD:     if (out_free) state_nxt = ST_IDLE;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	// ---------------- sequencer: unit controls ----------------
	always_comb begin
		in_stall        = 1'b1;
		mul_ctl         = '0;
		div_ctl.load    = 1'b0;
		div_ctl.step    = 1'b0;
		div_ctl.divisor = DIV_BY_DGRAM;
		mul_mcand       = rtt_q;
		dividend        = '0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_AVG_LD: begin
				// numerator 4*rtt + 256*sample, divided by 5
				div_ctl.load    = 1'b1;
				div_ctl.divisor = DIV_BY_FIVE;
				dividend        = DIV_WIDTH'({rtt_q, 2'b00}) + DIV_WIDTH'({sample_q, 8'h00});
			end
			ST_AVG_RUN: begin
				div_ctl.step    = 1'b1;
				div_ctl.divisor = DIV_BY_FIVE;
			end
			ST_MA_LD: begin
				mul_ctl.load = 1'b1;
				mul_mcand    = 32'(lat_q);
			end
			ST_MA_RUN: mul_ctl.step = 1'b1;
			ST_DA_LD: begin
				div_ctl.load = 1'b1;
				dividend     = DIV_WIDTH'(product[41:TERM_A_SHIFT]);
			end
			ST_DA_RUN: div_ctl.step = 1'b1;
			ST_MB_LD: begin
				mul_ctl.load = 1'b1;
				mul_mcand    = rtt_q;
			end
			ST_MB_RUN: mul_ctl.step = 1'b1;
			ST_DB_LD: begin
				div_ctl.load = 1'b1;
				dividend     = DIV_WIDTH'(product[63:TERM_B_SHIFT]);
			end
			ST_DB_RUN: div_ctl.step = 1'b1;
			ST_UPD: ;
			default: ;
		endcase
	end

	// ---------------- window decision ----------------
	assign avg_sat   = (quotient[DIV_WIDTH-1:32] != '0) ? 32'hFFFF_FFFF : quotient[31:0];
	// saturation of the capacity does not matter against an 8-bit window
	assign capacity  = 45'(term_a_q) + 45'(quotient);
	assign grow      = capacity > 45'(window_q);
	// a zero cap or floor acts as one
	assign cap_eff   = (cap_q == '0) ? 8'd1 : cap_q;
	assign floor_eff = (floor_q == '0) ? 8'd1 : floor_q;
	assign win_inc   = {1'b0, window_q} + 9'd1;

	always_comb begin
		if (grow) begin
			window_nxt = (win_inc > {1'b0, cap_eff}) ? cap_eff : win_inc[7:0];
		end else if ({1'b0, window_q} >= ({1'b0, step_q} + {1'b0, floor_eff})) begin
			window_nxt = window_q - step_q;
		end else begin
			window_nxt = floor_eff;
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			window_q    <= WINDOW_RST;
			rtt_q       <= '0;
			cap_q       <= WINDOW_CAP_RST;
			floor_q     <= WINDOW_FLOOR_RST;
			step_q      <= BACKOFF_STEP_RST;
			lat_q       <= LATENCY_TGT_RST;
		end else begin
			state_q <= state_nxt;

			// digit counter: load on each pass, count down while running
			unique case (state_q)
				ST_AVG_LD, ST_DA_LD, ST_DB_LD: cnt_q <= CNT_BITS'(DIV_DIGITS - 1);
				ST_MA_LD, ST_MB_LD:            cnt_q <= CNT_BITS'(MUL_DIGITS - 1);
				default:                       if (!cnt_done) cnt_q <= cnt_q - 1'b1;
			endcase

			// the averaging divide is done by the time the first product starts
			if (state_q == ST_MA_LD) rtt_q <= avg_sat;

			if (state_q == ST_UPD && out_free) begin
				window_q    <= window_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_WINDOW_CAP:   cap_q   <= cfg_data[7:0];
					CFG_WINDOW_FLOOR: floor_q <= cfg_data[7:0];
					CFG_BACKOFF_STEP: step_q  <= cfg_data[7:0];
					CFG_LATENCY_TGT:  lat_q   <= cfg_data;
					default: ;  // drop writes beyond the register list
				endcase
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= (ack_time - send_time) & SAMPLE_MASK;
			bw_q     <= bandwidth;
		end
		// hold term_a while the divider is reused for term_b
		if (state_q == ST_MB_LD) term_a_q <= quotient[29:0];
		if (state_q == ST_UPD && out_free) begin
			out_window_q <= window_nxt;
			out_rtt_q    <= rtt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign window       = out_window_q;
	assign rtt_smoothed = out_rtt_q;

	// ---------------- assertions ----------------
	a_window_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		window_q != '0)
		else $error("window register reached zero");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("item channel open right after an item was taken");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_UPD))
		else $error("result shown without an update step");

	a_out_window_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> window != '0)
		else $error("zero window delivered");

endmodule
